/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KM_ASSERT_IMP(name, a, b) \
   name: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("assertion failed");

// next-cycle implication
`define KM_ASSERT_NEXT(name, a, b) \
   name: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("assertion failed");

`endif

/* design/km_pkg.sv */
// ----------------------------------------------------------------------------
// k-means package
// Shared constants, codes and types of the k-means clustering unit.
// ----------------------------------------------------------------------------
package km_pkg;

   localparam int MAX_POINTS_DEF   = 1024;
   localparam int MAX_CLUSTERS_DEF = 8;
   localparam int MAX_DIMS_DEF     = 8;

   localparam logic [1:0] ACT_POINT    = 2'd0;
   localparam logic [1:0] ACT_CENTROID = 2'd1;
   localparam logic [1:0] ACT_RUN      = 2'd2;

   localparam logic [1:0] REG_CLUSTERS   = 2'd0;
   localparam logic [1:0] REG_DIMS       = 2'd1;
   localparam logic [1:0] REG_POINTS     = 2'd2;
   localparam logic [1:0] REG_ITERATIONS = 2'd3;

   localparam logic [3:0]  CLUSTERS_RST   = 4'd2;
   localparam logic [3:0]  DIMS_RST       = 4'd2;
   localparam logic [10:0] POINTS_RST     = 11'd1;
   localparam logic [9:0]  ITERATIONS_RST = 10'd300;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } dist_ctl_type;

endpackage

/* design/km_dist.sv */
// ----------------------------------------------------------------------------
// k-means distance unit
// Pipelined squared-difference accumulator, one coordinate pair per cycle.
// ----------------------------------------------------------------------------
module km_dist #(
   parameter  int MAX_CLUSTERS = km_pkg::MAX_CLUSTERS_DEF,
   parameter  int MAX_DIMS     = km_pkg::MAX_DIMS_DEF,
   localparam int CIW          = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
   localparam int AW           = 65 + $clog2(MAX_DIMS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  km_pkg::dist_ctl_type       in_ctl,
   input  logic [CIW-1:0]             in_tag,
   input  logic signed [31:0]         point_coord,
   input  logic signed [31:0]         centroid_coord,
   output logic                       out_valid,
   output logic [CIW-1:0]             out_tag,
   output logic [AW-1:0]              out_dist,
   output logic                       active
);
   km_pkg::dist_ctl_type a_ctl_ff, a_ctl_in, b_ctl_ff, b_ctl_in;
   logic [CIW-1:0]       a_tag_ff, b_tag_ff, out_tag_ff;
   logic [32:0]          mag_ff, mag_in;
   logic signed [32:0]   diff;
   logic [63:0]          prod;
   logic [64:0]          sq_ff, sq_in;
   logic [AW-1:0]        acc_ff, acc_in;
   logic                 out_v_ff, out_v_in;

   always_comb begin
      diff     = $signed({point_coord[31], point_coord})
               - $signed({centroid_coord[31], centroid_coord});
      mag_in   = diff[32] ? 33'(-diff) : 33'(diff);
      a_ctl_in = in_ctl;
      prod     = mag_ff[31:0] * mag_ff[31:0];
      sq_in    = mag_ff[32] ? {1'b1, 64'd0} : {1'b0, prod};
      b_ctl_in = a_ctl_ff;
      acc_in   = (b_ctl_ff.first ? '0 : acc_ff) + AW'(sq_ff);
      out_v_in = b_ctl_ff.valid && b_ctl_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         a_ctl_ff <= a_ctl_in;
         b_ctl_ff <= b_ctl_in;
         out_v_ff <= out_v_in;
      end
      mag_ff   <= mag_in;
      a_tag_ff <= in_tag;
      sq_ff    <= sq_in;
      b_tag_ff <= a_tag_ff;
      if (b_ctl_ff.valid) begin
         acc_ff     <= acc_in;
         out_tag_ff <= b_tag_ff;
      end
   end

   assign out_valid = out_v_ff;
   assign out_tag   = out_tag_ff;
   assign out_dist  = acc_ff;
   assign active    = a_ctl_ff.valid || b_ctl_ff.valid || out_v_ff;

endmodule

/* design/km_div.sv */
// ----------------------------------------------------------------------------
// k-means divider
// Restoring signed-by-unsigned divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module km_div #(
   parameter int SW  = 42,
   parameter int NW  = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [SW-1:0] dividend,
   input  logic [NW-1:0]        divisor,
   output logic                 done,
   output logic [31:0]          quotient
);
   localparam int IW = $clog2(SW + 1);

   logic          run_ff, run_in, done_ff, done_in, neg_ff, neg_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] num_ff, num_in;
   logic [NW-1:0] rem_ff, rem_in, div_ff, div_in;
   logic [NW:0]   trial;
   logic          ge;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, num_ff[SW-1]};
      ge      = trial >= {1'b0, div_ff};
      if (start) begin
         run_in = 1'b1;
         neg_in = dividend[SW-1];
         num_in = dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
         rem_in = '0;
         div_in = divisor;
         cnt_in = IW'(SW);
      end else if (run_ff) begin
         rem_in = ge ? NW'(trial - {1'b0, div_ff}) : trial[NW-1:0];
         num_in = {num_ff[SW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == IW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? 32'(-num_ff[31:0]) : num_ff[31:0];

endmodule

/* design/kmeans_lloyd_clustering_unit.sv */
// Loads: one coordinate per cycle while idle, no results, ready again next cycle.
// Run: R rounds of assign, sum and update, then the report; the pace is set by the shared
// distance pipeline (one pair a cycle) and the bit-serial divider, SW = 32+log2(MAX_POINTS)
// bits wide. Zero rounds: straight to the report.
// Report: one coordinate a cycle, K*D strobes ending with last.
// Reset: synchronous; control regs reset to defaults, stores undefined until written.
// ----------------------------------------------------------------------------
// k-means clustering unit
// Lloyd k-means over stored Q16.16 points under a small sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kmeans_lloyd_clustering_unit #(
   parameter int MAX_POINTS   = km_pkg::MAX_POINTS_DEF,
   parameter int MAX_CLUSTERS = km_pkg::MAX_CLUSTERS_DEF,
   parameter int MAX_DIMS     = km_pkg::MAX_DIMS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic [9:0]         req_row_index,
   input  logic [2:0]         req_coord_index,
   input  logic signed [31:0] req_coord_value,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_cluster_number,
   output logic [2:0]         rsp_coord_position,
   output logic signed [31:0] rsp_centroid_value,
   output logic               rsp_was_empty,
   output logic               rsp_last,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   localparam int CIW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int DIW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int PIW    = $clog2(MAX_POINTS);
   localparam int KW     = $clog2(MAX_CLUSTERS + 1);
   localparam int DW     = $clog2(MAX_DIMS + 1);
   localparam int NW     = $clog2(MAX_POINTS + 1);
   localparam int PDEPTH = MAX_POINTS * MAX_DIMS;
   localparam int PAW    = $clog2(PDEPTH);
   localparam int CDEPTH = MAX_CLUSTERS * MAX_DIMS;
   localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
   localparam int SW     = 32 + PIW;
   localparam int AW     = 65 + $clog2(MAX_DIMS);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DIST   = 7'b0000010,
      ST_SUM    = 7'b0000100,
      ST_UPRD   = 7'b0001000,
      ST_UPGO   = 7'b0010000,
      ST_UPWAIT = 7'b0100000,
      ST_REPORT = 7'b1000000
   } state_type;

   state_type      state_ff, state_in;

   logic [3:0]     cfg_k_ff, cfg_k_in, cfg_d_ff, cfg_d_in;
   logic [10:0]    cfg_n_ff, cfg_n_in;
   logic [9:0]     cfg_iter_ff, cfg_iter_in;
   logic           csr_wr;

   logic [KW-1:0]  k_ff, k_in, k_clamp;
   logic [DW-1:0]  d_ff, d_in, d_clamp;
   logic [NW-1:0]  n_ff, n_in, n_clamp;
   logic           ran_ff, ran_in;
   logic [9:0]     round_ff, round_in;

   logic           iss_ff, iss_in;
   logic [CIW-1:0] ic_ff, ic_in;
   logic [DIW-1:0] ij_ff, ij_in;
   logic [PIW-1:0] p_ff, p_in;
   logic [PAW-1:0] pbase_ff, pbase_in;

   logic [CIW-1:0] best_c_ff, best_c_in;
   logic [AW-1:0]  best_d_ff, best_d_in;

   logic [NW-1:0]  cnt_ff [MAX_CLUSTERS];
   logic           cnt_clr, cnt_inc;
   logic           svld_ff [CDEPTH];
   logic           svld_clr;

   km_pkg::dist_ctl_type s1_ctl_ff, s1_ctl_in;
   logic [CIW-1:0] s1_tag_ff;
   logic           dist_valid, dist_active;
   logic [CIW-1:0] dist_tag;
   logic [AW-1:0]  dist_val;

   logic           sum_v_ff, sum_v_in;
   logic [CAW-1:0] sum_wa_ff;

   logic           rpt_v_ff, rpt_v_in, rpt_last_ff, rpt_last_in, rpt_empty_ff, rpt_empty_in;
   logic [2:0]     rpt_c_ff, rpt_j_ff;

   logic [31:0]    pmem [PDEPTH];
   logic [31:0]    pmem_rd_ff;
   logic [PAW-1:0] pmem_ra, pmem_wa;
   logic           pmem_we;

   logic [31:0]    cmem [CDEPTH];
   logic [31:0]    cmem_rd_ff, cmem_wd;
   logic [CAW-1:0] cmem_ra, cmem_wa;
   logic           cmem_we;

   logic [SW-1:0]  smem [CDEPTH];
   logic [SW-1:0]  smem_rd_ff, smem_wd;
   logic           smem_vld_rd_ff;
   logic [CAW-1:0] smem_ra;

   logic           div_start, div_done;
   logic [31:0]    div_q;
   logic           accept, last_c, last_j, last_p;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign accept     = start && (state_ff == ST_IDLE);
   assign busy       = (state_ff != ST_IDLE);

   always_comb begin
      case (csr_paddr[3:2])
         km_pkg::REG_CLUSTERS:   csr_prdata = {28'd0, cfg_k_ff};
         km_pkg::REG_DIMS:       csr_prdata = {28'd0, cfg_d_ff};
         km_pkg::REG_POINTS:     csr_prdata = {21'd0, cfg_n_ff};
         km_pkg::REG_ITERATIONS: csr_prdata = {22'd0, cfg_iter_ff};
         default:                csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg_k_in    = cfg_k_ff;
      cfg_d_in    = cfg_d_ff;
      cfg_n_in    = cfg_n_ff;
      cfg_iter_in = cfg_iter_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            km_pkg::REG_CLUSTERS:   cfg_k_in    = csr_pwdata[3:0];
            km_pkg::REG_DIMS:       cfg_d_in    = csr_pwdata[3:0];
            km_pkg::REG_POINTS:     cfg_n_in    = csr_pwdata[10:0];
            km_pkg::REG_ITERATIONS: cfg_iter_in = csr_pwdata[9:0];
            default: ;
         endcase
      end
      if (cfg_k_ff == 4'd0)                    k_clamp = KW'(1);
      else if (int'(cfg_k_ff) > MAX_CLUSTERS)  k_clamp = KW'(MAX_CLUSTERS);
      else                                     k_clamp = KW'(cfg_k_ff);
      if (cfg_d_ff == 4'd0)                    d_clamp = DW'(1);
      else if (int'(cfg_d_ff) > MAX_DIMS)      d_clamp = DW'(MAX_DIMS);
      else                                     d_clamp = DW'(cfg_d_ff);
      if (cfg_n_ff == 11'd0)                   n_clamp = NW'(1);
      else if (int'(cfg_n_ff) > MAX_POINTS)    n_clamp = NW'(MAX_POINTS);
      else                                     n_clamp = NW'(cfg_n_ff);
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      d_in         = d_ff;
      n_in         = n_ff;
      ran_in       = ran_ff;
      round_in     = round_ff;
      iss_in       = iss_ff;
      ic_in        = ic_ff;
      ij_in        = ij_ff;
      p_in         = p_ff;
      pbase_in     = pbase_ff;
      best_c_in    = best_c_ff;
      best_d_in    = best_d_ff;
      cnt_clr      = 1'b0;
      cnt_inc      = 1'b0;
      svld_clr     = 1'b0;
      s1_ctl_in    = '0;
      sum_v_in     = 1'b0;
      rpt_v_in     = 1'b0;
      rpt_last_in  = 1'b0;
      rpt_empty_in = 1'b0;
      div_start    = 1'b0;
      cmem_we      = 1'b0;
      cmem_wa      = CAW'(int'(req_row_index) * MAX_DIMS + int'(req_coord_index));
      cmem_wd      = req_coord_value;
      cmem_ra      = CAW'(int'(ic_ff) * MAX_DIMS + int'(ij_ff));
      pmem_ra      = PAW'(int'(pbase_ff) + int'(ij_ff));
      pmem_wa      = PAW'(int'(req_row_index) * MAX_DIMS + int'(req_coord_index));
      pmem_we      = 1'b0;
      smem_ra      = CAW'(int'(best_c_ff) * MAX_DIMS + int'(ij_ff));
      last_c       = (int'(ic_ff) == int'(k_ff) - 1);
      last_j       = (int'(ij_ff) == int'(d_ff) - 1);
      last_p       = (int'(p_ff) == int'(n_ff) - 1);

      if (dist_valid && (dist_tag == '0 || dist_val < best_d_ff)) begin
         best_c_in = dist_tag;
         best_d_in = dist_val;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  km_pkg::ACT_POINT:
                     pmem_we = (int'(req_row_index) < MAX_POINTS)
                            && (int'(req_coord_index) < MAX_DIMS);
                  km_pkg::ACT_CENTROID:
                     cmem_we = (int'(req_row_index) < MAX_CLUSTERS)
                            && (int'(req_coord_index) < MAX_DIMS);
                  km_pkg::ACT_RUN: begin
                     k_in     = k_clamp;
                     d_in     = d_clamp;
                     n_in     = n_clamp;
                     ic_in    = '0;
                     ij_in    = '0;
                     iss_in   = 1'b1;
                     round_in = '0;
                     if (cfg_iter_ff == 10'd0) begin
                        ran_in   = 1'b0;
                        state_in = ST_REPORT;
                     end else begin
                        ran_in   = 1'b1;
                        p_in     = '0;
                        pbase_in = '0;
                        cnt_clr  = 1'b1;
                        svld_clr = 1'b1;
                        state_in = ST_DIST;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIST: begin
            if (iss_ff) begin
               s1_ctl_in = '{valid: 1'b1, first: (ij_ff == '0), last: last_j};
               if (last_j) begin
                  ij_in = '0;
                  if (last_c) iss_in = 1'b0;
                  else        ic_in  = ic_ff + 1'b1;
               end else begin
                  ij_in = ij_ff + 1'b1;
               end
            end else if (!s1_ctl_ff.valid && !dist_active) begin
               cnt_inc  = 1'b1;
               iss_in   = 1'b1;
               ij_in    = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (iss_ff) begin
               sum_v_in = 1'b1;
               if (last_j) iss_in = 1'b0;
               else        ij_in  = ij_ff + 1'b1;
            end else if (!sum_v_ff) begin
               ic_in  = '0;
               ij_in  = '0;
               if (last_p) begin
                  state_in = ST_UPRD;
               end else begin
                  p_in     = p_ff + 1'b1;
                  pbase_in = PAW'(int'(pbase_ff) + MAX_DIMS);
                  iss_in   = 1'b1;
                  state_in = ST_DIST;
               end
            end
         end
         ST_UPRD: begin
            smem_ra = CAW'(int'(ic_ff) * MAX_DIMS + int'(ij_ff));
            if (cnt_ff[ic_ff] != '0) begin
               state_in = ST_UPGO;
            end else if (!last_c) begin
               ic_in = ic_ff + 1'b1;
               ij_in = '0;
            end else if (round_ff + 1'b1 == cfg_iter_ff) begin
               ic_in    = '0;
               ij_in    = '0;
               iss_in   = 1'b1;
               state_in = ST_REPORT;
            end else begin
               round_in = round_ff + 1'b1;
               ic_in    = '0;
               ij_in    = '0;
               p_in     = '0;
               pbase_in = '0;
               cnt_clr  = 1'b1;
               svld_clr = 1'b1;
               iss_in   = 1'b1;
               state_in = ST_DIST;
            end
         end
         ST_UPGO: begin
            div_start = 1'b1;
            state_in  = ST_UPWAIT;
         end
         ST_UPWAIT: begin
            if (div_done) begin
               cmem_we = 1'b1;
               cmem_wa = CAW'(int'(ic_ff) * MAX_DIMS + int'(ij_ff));
               cmem_wd = div_q;
               state_in = ST_UPRD;
               if (!last_j) begin
                  ij_in = ij_ff + 1'b1;
               end else if (!last_c) begin
                  ij_in = '0;
                  ic_in = ic_ff + 1'b1;
               end else if (round_ff + 1'b1 == cfg_iter_ff) begin
                  ic_in    = '0;
                  ij_in    = '0;
                  iss_in   = 1'b1;
                  state_in = ST_REPORT;
               end else begin
                  round_in = round_ff + 1'b1;
                  ic_in    = '0;
                  ij_in    = '0;
                  p_in     = '0;
                  pbase_in = '0;
                  cnt_clr  = 1'b1;
                  svld_clr = 1'b1;
                  iss_in   = 1'b1;
                  state_in = ST_DIST;
               end
            end
         end
         ST_REPORT: begin
            rpt_v_in     = 1'b1;
            rpt_last_in  = last_c && last_j;
            rpt_empty_in = ran_ff && (cnt_ff[ic_ff] == '0);
            if (last_j) begin
               ij_in = '0;
               if (last_c) begin
                  iss_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  ic_in = ic_ff + 1'b1;
               end
            end else begin
               ij_in = ij_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign smem_wd = (smem_vld_rd_ff ? smem_rd_ff : '0)
                  + {{(SW-32){pmem_rd_ff[31]}}, pmem_rd_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cfg_k_ff    <= km_pkg::CLUSTERS_RST;
         cfg_d_ff    <= km_pkg::DIMS_RST;
         cfg_n_ff    <= km_pkg::POINTS_RST;
         cfg_iter_ff <= km_pkg::ITERATIONS_RST;
         iss_ff      <= 1'b0;
         s1_ctl_ff   <= '0;
         sum_v_ff    <= 1'b0;
         rpt_v_ff    <= 1'b0;
         ran_ff      <= 1'b0;
         for (int i = 0; i < MAX_CLUSTERS; i++) cnt_ff[i] <= '0;
         for (int i = 0; i < CDEPTH; i++) svld_ff[i] <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cfg_k_ff    <= cfg_k_in;
         cfg_d_ff    <= cfg_d_in;
         cfg_n_ff    <= cfg_n_in;
         cfg_iter_ff <= cfg_iter_in;
         iss_ff      <= iss_in;
         s1_ctl_ff   <= s1_ctl_in;
         sum_v_ff    <= sum_v_in;
         rpt_v_ff    <= rpt_v_in;
         ran_ff      <= ran_in;
         if (cnt_clr) begin
            for (int i = 0; i < MAX_CLUSTERS; i++) cnt_ff[i] <= '0;
         end else if (cnt_inc) begin
            cnt_ff[best_c_ff] <= cnt_ff[best_c_ff] + 1'b1;
         end
         if (svld_clr) begin
            for (int i = 0; i < CDEPTH; i++) svld_ff[i] <= 1'b0;
         end else if (sum_v_ff) begin
            svld_ff[sum_wa_ff] <= 1'b1;
         end
      end
      k_ff         <= k_in;
      d_ff         <= d_in;
      n_ff         <= n_in;
      round_ff     <= round_in;
      ic_ff        <= ic_in;
      ij_ff        <= ij_in;
      p_ff         <= p_in;
      pbase_ff     <= pbase_in;
      best_c_ff    <= best_c_in;
      best_d_ff    <= best_d_in;
      s1_tag_ff    <= ic_ff;
      sum_wa_ff    <= smem_ra;
      rpt_last_ff  <= rpt_last_in;
      rpt_empty_ff <= rpt_empty_in;
      rpt_c_ff     <= 3'(ic_ff);
      rpt_j_ff     <= 3'(ij_ff);
   end

   always_ff @(posedge clock) begin
      if (pmem_we) pmem[pmem_wa] <= req_coord_value;
      pmem_rd_ff <= pmem[pmem_ra];
   end

   always_ff @(posedge clock) begin
      if (cmem_we) cmem[cmem_wa] <= cmem_wd;
      cmem_rd_ff <= cmem[cmem_ra];
   end

   always_ff @(posedge clock) begin
      if (sum_v_ff) smem[sum_wa_ff] <= smem_wd;
      smem_rd_ff     <= smem[smem_ra];
      smem_vld_rd_ff <= svld_ff[smem_ra];
   end

   km_dist #(
      .MAX_CLUSTERS (MAX_CLUSTERS),
      .MAX_DIMS     (MAX_DIMS)
   ) u_dist (
      .clock          (clock),
      .reset          (reset),
      .in_ctl         (s1_ctl_ff),
      .in_tag         (s1_tag_ff),
      .point_coord    (pmem_rd_ff),
      .centroid_coord (cmem_rd_ff),
      .out_valid      (dist_valid),
      .out_tag        (dist_tag),
      .out_dist       (dist_val),
      .active         (dist_active)
   );

   km_div #(
      .SW (SW),
      .NW (NW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (smem_vld_rd_ff ? smem_rd_ff : '0),
      .divisor  (cnt_ff[ic_ff]),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_strobe         = rpt_v_ff;
   assign rsp_cluster_number = rpt_c_ff;
   assign rsp_coord_position = rpt_j_ff;
   assign rsp_centroid_value = cmem_rd_ff;
   assign rsp_was_empty      = rpt_empty_ff;
   assign rsp_last           = rpt_last_ff;

   `KM_ASSERT_NEXT(a_last_ends_report, rsp_strobe && rsp_last, !rsp_strobe)
   `KM_ASSERT_NEXT(a_run_goes_busy, accept && req_action == km_pkg::ACT_RUN, busy)
   `KM_ASSERT_IMP(a_div_done_in_wait, div_done, state_ff == ST_UPWAIT)
   `KM_ASSERT_IMP(a_strobe_from_report, rsp_strobe, $past(state_ff) == ST_REPORT)

endmodule
